@@ rtl/wqr_pkg.sv @@
`default_nettype none

package wqr_pkg;

    localparam int QUEUE_SLOTS = 16;
    localparam int ID_BITS     = 8;

    localparam int ACTION_BITS = 2;
    localparam int STATUS_BITS = 2;

    // Request codes
    localparam logic [ACTION_BITS-1:0] ACT_APPEND      = 2'd0;
    localparam logic [ACTION_BITS-1:0] ACT_REMOVE_HEAD = 2'd1;
    localparam logic [ACTION_BITS-1:0] ACT_REMOVE_ID   = 2'd2;

    // Result status codes
    localparam logic [STATUS_BITS-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_FULL      = 2'd2;
    localparam logic [STATUS_BITS-1:0] ST_DUPLICATE = 2'd3;

    // Per-cycle command broadcast to every cell of the row.
    typedef struct packed {
        logic append_en;
        logic remove_head_en;
        logic remove_id_en;
    } cell_ctrl_t;

endpackage

`default_nettype wire

@@ rtl/wqr_if.sv @@
`default_nettype none

interface wqr_req_if #(
    parameter int ID_BITS = wqr_pkg::ID_BITS
);
    logic                                valid;
    logic                                ready;
    logic [wqr_pkg::ACTION_BITS-1:0]     action;
    logic [ID_BITS-1:0]                  waiter_id;

    modport source (output valid, output action, output waiter_id, input ready);
    modport sink   (input valid, input action, input waiter_id, output ready);
endinterface

interface wqr_rsp_if #(
    parameter int ID_BITS = wqr_pkg::ID_BITS
);
    logic                                valid;
    logic                                ready;
    logic [wqr_pkg::STATUS_BITS-1:0]     status;
    logic [ID_BITS-1:0]                  removed_id;
    logic                                queue_empty;

    modport source (output valid, output status, output removed_id,
                    output queue_empty, input ready);
    modport sink   (input valid, input status, input removed_id,
                    input queue_empty, output ready);
endinterface

`default_nettype wire

@@ rtl/wqr_cell.sv @@
`default_nettype none

module wqr_cell #(
    parameter int ID_BITS = wqr_pkg::ID_BITS
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire wqr_pkg::cell_ctrl_t ctrl,
    input  wire logic [ID_BITS-1:0]  req_id,
    input  wire logic                prev_valid,
    input  wire logic [ID_BITS-1:0]  next_id,
    input  wire logic                next_valid,
    input  wire logic                seen_in,
    output logic                     seen_out,
    output logic [ID_BITS-1:0]       id,
    output logic                     valid
);

    logic [ID_BITS-1:0] id_reg;
    logic [ID_BITS-1:0] id_next;
    logic               valid_reg;
    logic               valid_next;
    logic               match;
    logic               shift_here;
    logic               load_here;

    assign match    = valid_reg && (id_reg == req_id);
    assign seen_out = seen_in || match;

    // A removal closes the gap: this cell and every cell behind the removed
    // one take the word of their right-hand neighbor.
    assign shift_here = ctrl.remove_head_en || (ctrl.remove_id_en && seen_out);
    // The first empty cell after the occupied prefix is the tail slot.
    assign load_here  = ctrl.append_en && prev_valid && !valid_reg;

    always_comb
    begin
        id_next    = id_reg;
        valid_next = valid_reg;
        if (shift_here)
        begin
            id_next    = next_id;
            valid_next = next_valid;
        end
        else if (load_here)
        begin
            id_next    = req_id;
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg <= id_next;
    end

    assign id    = id_reg;
    assign valid = valid_reg;

endmodule

`default_nettype wire

@@ rtl/wait_queue_with_removal.sv @@
`default_nettype none

// First-in first-out queue of waiter ids with removal by id. Each request
// word is applied in the cycle it is accepted: every cell of the row compares
// its id with the request in parallel, and on a removal the cells behind the
// removed entry take their neighbor's id, so the queue stays compacted with
// the head in cell 0. One request is taken per clock while the output
// register is empty or its waiting result is taken in the same cycle; the
// result word appears in that register on the next cycle. Appending an id
// already queued returns the duplicate status, appending to a full queue the
// full status; both leave the queue unchanged. The queue comes out of reset
// empty and needs no initialization time.
module wait_queue_with_removal #(
    parameter int QUEUE_SLOTS = wqr_pkg::QUEUE_SLOTS,
    parameter int ID_BITS     = wqr_pkg::ID_BITS
) (
    input  wire logic clk,
    input  wire logic rst_n,
    wqr_req_if.sink   req,
    wqr_rsp_if.source rsp
);

    logic [ID_BITS-1:0]  cell_id    [QUEUE_SLOTS];
    logic                cell_valid [QUEUE_SLOTS];
    logic                seen       [QUEUE_SLOTS];
    wqr_pkg::cell_ctrl_t ctrl;

    logic                            fire;
    logic                            any_match;
    logic                            full;
    logic [wqr_pkg::STATUS_BITS-1:0] status_next;
    logic [ID_BITS-1:0]              removed_next;
    logic                            empty_next;

    logic                            out_valid_reg;
    logic [wqr_pkg::STATUS_BITS-1:0] status_reg;
    logic [ID_BITS-1:0]              removed_reg;
    logic                            empty_reg;

    assign req.ready = !out_valid_reg || rsp.ready;
    assign fire      = req.valid && req.ready;

    genvar g;
    generate
        for (g = 0; g < QUEUE_SLOTS; g++)
        begin : g_cell
            logic               prev_valid_w;
            logic [ID_BITS-1:0] next_id_w;
            logic               next_valid_w;
            logic               seen_in_w;

            if (g == 0)
            begin : g_head
                assign prev_valid_w = 1'b1;
                assign seen_in_w    = 1'b0;
            end
            else
            begin : g_body
                assign prev_valid_w = cell_valid[g-1];
                assign seen_in_w    = seen[g-1];
            end

            if (g == QUEUE_SLOTS - 1)
            begin : g_tail
                assign next_id_w    = '0;
                assign next_valid_w = 1'b0;
            end
            else
            begin : g_inner
                assign next_id_w    = cell_id[g+1];
                assign next_valid_w = cell_valid[g+1];
            end

            wqr_cell #(
                .ID_BITS (ID_BITS)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .req_id     (req.waiter_id),
                .prev_valid (prev_valid_w),
                .next_id    (next_id_w),
                .next_valid (next_valid_w),
                .seen_in    (seen_in_w),
                .seen_out   (seen[g]),
                .id         (cell_id[g]),
                .valid      (cell_valid[g])
            );
        end
    endgenerate

    // The match flag ripples down the row, so the last cell knows whether
    // the id is queued anywhere.
    assign any_match = seen[QUEUE_SLOTS-1];
    assign full      = cell_valid[QUEUE_SLOTS-1];

    always_comb
    begin
        ctrl         = '0;
        status_next  = wqr_pkg::ST_NOT_FOUND;
        removed_next = '0;
        empty_next   = !cell_valid[0];
        case (req.action)
            wqr_pkg::ACT_APPEND:
            begin
                if (any_match)
                begin
                    status_next = wqr_pkg::ST_DUPLICATE;
                end
                else if (full)
                begin
                    status_next = wqr_pkg::ST_FULL;
                end
                else
                begin
                    status_next    = wqr_pkg::ST_OK;
                    ctrl.append_en = fire;
                    empty_next     = 1'b0;
                end
            end
            wqr_pkg::ACT_REMOVE_HEAD:
            begin
                if (cell_valid[0])
                begin
                    status_next         = wqr_pkg::ST_OK;
                    removed_next        = cell_id[0];
                    ctrl.remove_head_en = fire;
                    empty_next          = !cell_valid[1];
                end
            end
            wqr_pkg::ACT_REMOVE_ID:
            begin
                if (any_match)
                begin
                    status_next       = wqr_pkg::ST_OK;
                    ctrl.remove_id_en = fire;
                    empty_next        = !cell_valid[1];
                end
            end
            default:
            begin
                status_next = wqr_pkg::ST_NOT_FOUND;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            status_reg  <= status_next;
            removed_reg <= removed_next;
            empty_reg   <= empty_next;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = status_reg;
    assign rsp.removed_id  = removed_reg;
    assign rsp.queue_empty = empty_reg;

endmodule

`default_nettype wire

@@ test/wait_queue_with_removal_tb.sv @@
`timescale 1ns / 100ps

module wait_queue_with_removal_tb;

    typedef logic [wqr_pkg::ID_BITS-1:0]     wq_id_t;
    typedef logic [wqr_pkg::ACTION_BITS-1:0] wq_action_t;

    localparam wq_action_t ACT_UNUSED = 2'd3;
    localparam int RANDOM_REQUESTS = 1150;

    typedef struct packed {
        logic [wqr_pkg::ACTION_BITS-1:0] action;
        logic [wqr_pkg::ID_BITS-1:0]     waiter_id;
    } wq_request_t;

    typedef struct packed {
        logic [wqr_pkg::STATUS_BITS-1:0] status;
        logic [wqr_pkg::ID_BITS-1:0]     removed_id;
        logic                            queue_empty;
    } wq_result_t;

    logic clk;
    logic rst_n;

    wqr_req_if req_ch ();
    wqr_rsp_if rsp_ch ();

    wait_queue_with_removal dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    wq_request_t        pending_requests[$];
    wq_result_t         expected_results[$];
    wq_id_t             waiters[$];   // predicted queue contents, head first
    wq_id_t             plan_ids[$];  // queue contents as the stimulus plans them
    wq_request_t        next_req;
    wq_result_t         want;
    int                 total_requests = 0;
    int                 requests_taken = 0;
    int                 results_seen = 0;
    int                 mismatches = 0;
    int                 status_seen[4] = '{0, 0, 0, 0};

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // The first third of the run stalls the receiver harder, the second third
    // the sender, and the last third runs at full rate.
    function automatic int idle_percent(input bit sender);
        int phase;
        phase = (total_requests == 0) ? 0 : (requests_taken * 3) / total_requests;
        if (phase == 0)
            return sender ? 34 : 48;
        else if (phase == 1)
            return sender ? 48 : 34;
        return 0;
    endfunction

    function automatic int find_waiter(input wq_id_t id);
        foreach (waiters[i])
            if (waiters[i] == id)
                return i;
        return -1;
    endfunction

    function automatic int plan_find(input wq_id_t id);
        foreach (plan_ids[i])
            if (plan_ids[i] == id)
                return i;
        return -1;
    endfunction

    // Applies one request to the predicted queue and returns its result word.
    function automatic wq_result_t serve_request(input wq_action_t act,
                                                 input wq_id_t id);
        wq_result_t r;
        int pos;
        r.status = wqr_pkg::ST_OK;
        r.removed_id = '0;
        pos = find_waiter(id);
        case (act)
            wqr_pkg::ACT_APPEND:
            begin
                if (pos >= 0)
                    r.status = wqr_pkg::ST_DUPLICATE;
                else if (waiters.size() >= wqr_pkg::QUEUE_SLOTS)
                    r.status = wqr_pkg::ST_FULL;
                else
                    waiters.push_back(id);
            end
            wqr_pkg::ACT_REMOVE_HEAD:
            begin
                if (waiters.size() == 0)
                    r.status = wqr_pkg::ST_NOT_FOUND;
                else
                    r.removed_id = waiters.pop_front();
            end
            wqr_pkg::ACT_REMOVE_ID:
            begin
                if (pos < 0)
                    r.status = wqr_pkg::ST_NOT_FOUND;
                else
                    waiters.delete(pos);
            end
            default:
                r.status = wqr_pkg::ST_NOT_FOUND;
        endcase
        r.queue_empty = (waiters.size() == 0);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got_v, input int want_v);
        mismatches++;
        $display("%0t ns: %s: got %0d, expected %0d", $time, what, got_v, want_v);
    endtask

    task automatic queue_request(input wq_action_t act, input wq_id_t id);
        wq_request_t r;
        int pos;
        r.action = act;
        r.waiter_id = id;
        pending_requests.push_back(r);
        pos = plan_find(id);
        case (act)
            wqr_pkg::ACT_APPEND:
                if (pos < 0 && plan_ids.size() < wqr_pkg::QUEUE_SLOTS)
                    plan_ids.push_back(id);
            wqr_pkg::ACT_REMOVE_HEAD:
                if (plan_ids.size() != 0)
                    void'(plan_ids.pop_front());
            wqr_pkg::ACT_REMOVE_ID:
                if (pos >= 0)
                    plan_ids.delete(pos);
            default:
                ;
        endcase
    endtask

    function automatic wq_id_t absent_id();
        wq_id_t id;
        id = wq_id_t'($urandom_range(0, (1 << wqr_pkg::ID_BITS) - 1));
        while (plan_find(id) >= 0)
            id = wq_id_t'($urandom_range(0, (1 << wqr_pkg::ID_BITS) - 1));
        return id;
    endfunction

    function automatic wq_id_t queued_id();
        return plan_ids[$urandom_range(0, plan_ids.size() - 1)];
    endfunction

    // Request driver: a word that is offered stays on the bus until it is taken.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid     <= 1'b0;
            req_ch.action    <= wqr_pkg::ACT_APPEND;
            req_ch.waiter_id <= '0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                expected_results.push_back(serve_request(req_ch.action, req_ch.waiter_id));
                requests_taken++;
            end
            if (!req_ch.valid || req_ch.ready)
            begin
                if (pending_requests.size() != 0
                    && $urandom_range(0, 99) >= idle_percent(1'b1))
                begin
                    next_req = pending_requests.pop_front();
                    req_ch.valid     <= 1'b1;
                    req_ch.action    <= next_req.action;
                    req_ch.waiter_id <= next_req.waiter_id;
                end
                else
                begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor and receiver stalls.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                results_seen++;
                if (expected_results.size() == 0)
                begin
                    report_mismatch("result word with no request pending", rsp_ch.status, 0);
                end
                else
                begin
                    want = expected_results.pop_front();
                    status_seen[want.status]++;
                    if (rsp_ch.status !== want.status)
                        report_mismatch("status", rsp_ch.status, want.status);
                    if (rsp_ch.removed_id !== want.removed_id)
                        report_mismatch("removed_id", rsp_ch.removed_id, want.removed_id);
                    if (rsp_ch.queue_empty !== want.queue_empty)
                        report_mismatch("queue_empty", rsp_ch.queue_empty, want.queue_empty);
                end
            end
            rsp_ch.ready <= ($urandom_range(0, 99) >= idle_percent(1'b0));
        end
    end

    initial
    begin
        int mode;
        int pick;
        int sub;
        wq_id_t id;

        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.action = wqr_pkg::ACT_APPEND;
        req_ch.waiter_id = '0;
        rsp_ch.ready = 1'b0;

        // Empty queue corner cases, id extremes and a duplicate.
        queue_request(wqr_pkg::ACT_REMOVE_HEAD, 8'h00);
        queue_request(wqr_pkg::ACT_REMOVE_ID, 8'h00);
        queue_request(ACT_UNUSED, 8'hFF);
        queue_request(wqr_pkg::ACT_APPEND, 8'h00);
        queue_request(wqr_pkg::ACT_APPEND, 8'hFF);
        queue_request(wqr_pkg::ACT_APPEND, 8'hFF);
        queue_request(wqr_pkg::ACT_REMOVE_ID, 8'h55);
        queue_request(ACT_UNUSED, 8'h00);
        // Fill to capacity, then hit the full and duplicate checks together.
        for (int i = 1; i <= wqr_pkg::QUEUE_SLOTS - 2; i++)
            queue_request(wqr_pkg::ACT_APPEND, wq_id_t'(i * 17));
        queue_request(wqr_pkg::ACT_APPEND, 8'h5A);
        queue_request(wqr_pkg::ACT_APPEND, 8'h00);
        queue_request(wqr_pkg::ACT_REMOVE_ID, wq_id_t'(7 * 17));
        queue_request(wqr_pkg::ACT_REMOVE_ID, wq_id_t'((wqr_pkg::QUEUE_SLOTS - 2) * 17));
        queue_request(wqr_pkg::ACT_REMOVE_HEAD, 8'h33);

        // Random part: stretches that mostly fill, mostly drain, or mix.
        mode = 0;
        for (int n = 0; n < RANDOM_REQUESTS; n++)
        begin
            if (n % 40 == 0)
                mode = $urandom_range(0, 2);
            pick = $urandom_range(0, 99);
            sub = $urandom_range(0, 99);
            id = wq_id_t'($urandom_range(0, (1 << wqr_pkg::ID_BITS) - 1));
            if (pick < 3)
            begin
                queue_request(ACT_UNUSED, id);
            end
            else if (pick < (mode == 0 ? 70 : (mode == 1 ? 25 : 45)))
            begin
                if (sub < 12 && plan_ids.size() != 0)
                    queue_request(wqr_pkg::ACT_APPEND, queued_id());
                else
                    queue_request(wqr_pkg::ACT_APPEND, absent_id());
            end
            else if (pick < (mode == 0 ? 82 : (mode == 1 ? 60 : 70)))
            begin
                queue_request(wqr_pkg::ACT_REMOVE_HEAD, id);
            end
            else
            begin
                if (sub < 80 && plan_ids.size() != 0)
                    queue_request(wqr_pkg::ACT_REMOVE_ID, queued_id());
                else
                    queue_request(wqr_pkg::ACT_REMOVE_ID, id);
            end
        end
        total_requests = pending_requests.size();

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (requests_taken != total_requests)
            @(negedge clk);
        while (expected_results.size() != 0)
            @(negedge clk);
        repeat (6) @(negedge clk);

        $display("%0d requests applied, %0d result words checked, %0d mismatches",
                 requests_taken, results_seen, mismatches);
        $display("statuses seen: %0d ok, %0d not found, %0d full, %0d duplicate",
                 status_seen[wqr_pkg::ST_OK], status_seen[wqr_pkg::ST_NOT_FOUND],
                 status_seen[wqr_pkg::ST_FULL], status_seen[wqr_pkg::ST_DUPLICATE]);
        if (mismatches == 0)
            $display("wait_queue_with_removal regression: pass");
        else
            $display("wait_queue_with_removal regression: fail");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("timed out with %0d of %0d requests taken, %0d results outstanding",
                 requests_taken, total_requests, expected_results.size());
        $display("wait_queue_with_removal regression: fail");
        $finish;
    end

endmodule
